FILE: rtl/core/job_slot_priority_scheduler_top_defines.svh
// Assertion macros used by the job slot scheduler datapath.
`ifndef JOB_SLOT_PRIORITY_SCHEDULER_TOP_DEFINES_SVH
`define JOB_SLOT_PRIORITY_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define JSPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define JSPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/jsps_pkg.sv
// Shared types, constants and event codes of the job slot scheduler.
`default_nettype none

package jsps_pkg;

  // Number of job slots and the width of a slot index.
  localparam int unsigned SLOTS = 10;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Start value of the lowest-priority search for a new job.
  localparam logic signed [8:0] LOWEST_INIT = 9'(SLOTS - 1);

  // Event codes of a result.
  localparam logic [2:0] EV_REJECTED     = 3'd0;
  localparam logic [2:0] EV_STARTED      = 3'd1;
  localparam logic [2:0] EV_START_FAILED = 3'd2;
  localparam logic [2:0] EV_SUCCEEDED    = 3'd3;
  localparam logic [2:0] EV_FAILED       = 3'd4;

  // Input item.
  typedef struct packed {
    logic        op;
    logic [15:0] duration;
    logic        accepted;
    logic        start_check;
    logic        check_ok;
    logic        hold;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] slot;
    logic       last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       new_job;
    logic       clear_sel;
    logic       set_started;
    logic       disable_sel;
    logic       dec_rem;
    logic       raise;
    logic       emit;
    logic [2:0] emit_ev;
    logic       emit_last;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_tick;
    logic skip;
    logic accepted;
    logic found;
    logic started;
    logic start_fail;
    logic end_next;
    logic check_ok;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/jsps_datapath.sv
// Slot storage, slot scan, slot updates and result register.
`default_nettype none
`include "job_slot_priority_scheduler_top_defines.svh"

module jsps_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire jsps_pkg::in_item_t  in_data_i,
  input  wire jsps_pkg::cmd_t      cmd_i,
  output jsps_pkg::sts_t           sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output jsps_pkg::out_item_t      out_data_o
);
  import jsps_pkg::*;

  // Slot state.
  logic [SLOTS-1:0]   en_q, en_d;
  logic [SLOTS-1:0]   started_q, started_d;
  logic [SLOTS-1:0]   chkf_q, chkf_d;
  logic [15:0]        rem_q [SLOTS];
  logic [15:0]        rem_d [SLOTS];
  logic signed [7:0]  prio_q [SLOTS];
  logic signed [7:0]  prio_d [SLOTS];

  // Item and scan registers.
  in_item_t           item_q;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   sel_q, sel_d;
  logic               found_q, found_d;
  logic signed [7:0]  best_q, best_d;
  logic signed [8:0]  min_q, min_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic signed [8:0]  prio_m1;
  logic signed [7:0]  new_prio;
  logic [IDX_W+3:0]   sel_wide;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign sel_wide = {4'b0000, sel_q};

  // Clamp the new job's priority at the floor.
  assign new_prio = (min_q < 9'sh180) ? 8'sh80 : min_q[7:0];
  assign prio_m1  = $signed({prio_q[idx_q][7], prio_q[idx_q]}) - 9'sd1;

  // Scan one slot a cycle: first free slot and lowest priority, or best slot.
  always_comb begin
    idx_d   = idx_q;
    sel_d   = sel_q;
    found_d = found_q;
    best_d  = best_q;
    min_d   = min_q;
    if (cmd_i.load) begin
      idx_d   = '0;
      found_d = 1'b0;
      min_d   = LOWEST_INIT;
    end else if (cmd_i.step) begin
      idx_d = idx_q + 1'b1;
      if (!item_q.op) begin
        if (!found_q && !en_q[idx_q]) begin
          sel_d   = idx_q;
          found_d = 1'b1;
        end
        if (en_q[idx_q] && (prio_m1 < min_q)) begin
          min_d = prio_m1;
        end
      end else if (en_q[idx_q] && (!found_q || (prio_q[idx_q] > best_q))) begin
        sel_d   = idx_q;
        best_d  = prio_q[idx_q];
        found_d = 1'b1;
      end
    end
  end

  // Apply slot updates.
  always_comb begin
    en_d      = en_q;
    started_d = started_q;
    chkf_d    = chkf_q;
    rem_d     = rem_q;
    prio_d    = prio_q;
    if (cmd_i.new_job) begin
      en_d[sel_q]      = 1'b1;
      started_d[sel_q] = 1'b0;
      chkf_d[sel_q]    = item_q.start_check;
      rem_d[sel_q]     = item_q.duration;
      prio_d[sel_q]    = new_prio;
    end
    if (cmd_i.set_started) begin
      started_d[sel_q] = 1'b1;
    end
    if (cmd_i.disable_sel) begin
      en_d[sel_q] = 1'b0;
    end
    if (cmd_i.dec_rem && (rem_q[sel_q] != 16'd0)) begin
      rem_d[sel_q] = rem_q[sel_q] - 16'd1;
    end
    if (cmd_i.raise) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (en_q[i] && (IDX_W'(i) != sel_q) && (prio_q[i] != 8'sd127)) begin
          prio_d[i] = prio_q[i] + 8'sd1;
        end
      end
    end
    if (cmd_i.clear_sel) begin
      en_d[sel_q]      = 1'b0;
      started_d[sel_q] = 1'b0;
      chkf_d[sel_q]    = 1'b0;
      rem_d[sel_q]     = '0;
      prio_d[sel_q]    = '0;
    end
  end

  // Load a result, or drop it once transferred.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.emit) begin
      out_valid_d     = 1'b1;
      out_d.event_res = cmd_i.emit_ev;
      out_d.slot      = sel_wide[3:0];
      out_d.last      = cmd_i.emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= '0;
      started_q   <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      en_q        <= en_d;
      started_q   <= started_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    chkf_q <= chkf_d;
    rem_q  <= rem_d;
    prio_q <= prio_d;
    sel_q  <= sel_d;
    best_q <= best_d;
    min_q  <= min_d;
    out_q  <= out_d;
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.is_tick    = item_q.op;
    sts_o.skip       = item_q.hold;
    sts_o.accepted   = item_q.accepted;
    sts_o.found      = found_q;
    sts_o.started    = started_q[sel_q];
    sts_o.start_fail = chkf_q[sel_q] && !item_q.check_ok;
    sts_o.end_next   = (rem_q[sel_q] <= 16'd1);
    sts_o.check_ok   = item_q.check_ok;
    sts_o.scan_last  = (idx_q == IDX_W'(SLOTS - 1));
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `JSPS_ASSERT_IMP(a_new_job_free, cmd_i.new_job, !en_q[sel_q], "new job on an enabled slot")
  `JSPS_ASSERT_NXT(a_new_job_lands, cmd_i.new_job, en_q[$past(sel_q)], "new job not enabled")
  `JSPS_ASSERT_IMP(a_raise_on_end, cmd_i.raise, cmd_i.clear_sel, "raise without slot end")
  `JSPS_ASSERT_IMP(a_dec_started, cmd_i.dec_rem, en_q[sel_q] && started_q[sel_q], "bad decrement")
  `JSPS_ASSERT_IMP(a_no_overwrite, cmd_i.emit, out_free, "result overwritten before transfer")

endmodule

`default_nettype wire

FILE: rtl/core/jsps_ctrl.sv
// Controller state machine that sequences scan, decision and result steps.
`default_nettype none

module jsps_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire jsps_pkg::sts_t  sts_i,
  output jsps_pkg::cmd_t       cmd_o
);
  import jsps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_REJ   = 3'd3;
  localparam logic [2:0] S_SFAIL = 3'd4;
  localparam logic [2:0] S_START = 3'd5;
  localparam logic [2:0] S_COUNT = 3'd6;
  localparam logic [2:0] S_END   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts_i.is_tick) begin
          if (!sts_i.found) begin
            state_d = S_IDLE;
          end else if (sts_i.accepted) begin
            cmd_o.new_job = 1'b1;
            state_d       = S_IDLE;
          end else begin
            state_d = S_REJ;
          end
        end else if (sts_i.skip || !sts_i.found) begin
          state_d = S_IDLE;
        end else if (sts_i.started) begin
          state_d = S_COUNT;
        end else if (sts_i.start_fail) begin
          state_d = S_SFAIL;
        end else begin
          state_d = S_START;
        end
      end
      S_REJ: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_ev   = EV_REJECTED;
          cmd_o.emit_last = 1'b1;
          cmd_o.clear_sel = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SFAIL: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_ev     = EV_START_FAILED;
          cmd_o.emit_last   = 1'b1;
          cmd_o.set_started = 1'b1;
          cmd_o.disable_sel = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_START: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_ev     = EV_STARTED;
          cmd_o.emit_last   = !sts_i.end_next;
          cmd_o.set_started = 1'b1;
          state_d           = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.dec_rem = 1'b1;
        state_d       = sts_i.end_next ? S_END : S_IDLE;
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_ev   = sts_i.check_ok ? EV_SUCCEEDED : EV_FAILED;
          cmd_o.emit_last = 1'b1;
          cmd_o.clear_sel = 1'b1;
          cmd_o.raise     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/job_slot_priority_scheduler_top.sv
// An item scans all slots, one per cycle, then the decision state and any result states.
// A new item is taken only in the idle state, so each item finishes before the next one.
// Results register in a result state; a start result can be followed by the end result.
// A waiting result does not block the next transfer in until a new result must be loaded.
// Reset: asynchronous, clears slot enable and started flags, controller state and result valid; no clearing pass.
`default_nettype none

module job_slot_priority_scheduler_top (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire jsps_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output jsps_pkg::out_item_t       out_data_o
);
  import jsps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each item.
  jsps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold slot state and the result register.
  jsps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
